>>> rtl/hcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared types, codes and character helpers for the header card classifier.
// ----------------------------------------------------------------------------
package hcc_pkg;

	localparam int CARD_BYTES  = 80;
	localparam int COL_W       = $clog2(CARD_BYTES);
	localparam int BOOL_COLUMN = 29;
	localparam logic [COL_W-1:0] CARD_LAST = COL_W'(CARD_BYTES - 1);
	localparam logic [COL_W-1:0] EQ_COLUMN = COL_W'(8);

	localparam logic [7:0] CH_BLANK = 8'h20;
	localparam logic [7:0] CH_EQ    = "=";
	localparam logic [7:0] CH_SLASH = "/";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_T     = "T";
	localparam logic [7:0] CH_F     = "F";
	localparam logic [7:0] CH_DOT   = ".";
	localparam logic [7:0] CASE_BIT = 8'h20;

	localparam logic [63:0] NAME_SIMPLE   = "SIMPLE  ";
	localparam logic [63:0] NAME_XTENSION = "XTENSION";
	localparam logic [63:0] NAME_BITPIX   = "BITPIX  ";
	localparam logic [63:0] NAME_NAXIS    = "NAXIS   ";
	localparam logic [63:0] NAME_PCOUNT   = "PCOUNT  ";
	localparam logic [63:0] NAME_GCOUNT   = "GCOUNT  ";
	localparam logic [63:0] NAME_END      = "END     ";
	localparam logic [63:0] NAME_HISTORY  = "history ";
	localparam logic [63:0] NAME_COMMENT  = "comment ";
	localparam logic [63:0] NAME_BLANK    = "        ";
	localparam logic [39:0] NAXIS_STEM    = "NAXIS";

	typedef enum logic [2:0] {
		KIND_STRING,
		KIND_BOOL,
		KIND_NUMBER,
		KIND_NONE,
		KIND_CORRUPT,
		KIND_COMMENT,
		KIND_END
	} kind_t;

	typedef enum logic [3:0] {
		KW_OTHER,
		KW_SIMPLE,
		KW_XTENSION,
		KW_BITPIX,
		KW_NAXIS,
		KW_NAXISN,
		KW_PCOUNT,
		KW_GCOUNT,
		KW_END
	} kw_t;

	typedef enum logic [2:0] {
		DP_PRE,
		DP_NEEDDIG,
		DP_DIG,
		DP_OK,
		DP_FAIL
	} dphase_t;

	typedef enum logic [1:0] {
		HP_DIG,
		HP_TAIL,
		HP_DONE
	} hphase_t;

	typedef struct packed {
		logic [63:0]      name;
		logic             eq;
		logic             found;
		logic             hchk;
		logic             ishex;
		logic             djact;
		logic             djunk;
		logic             hneg;
		logic             hjunk;
		dphase_t          dphase;
		hphase_t          hphase;
		logic [7:0]       fvb;
		logic [COL_W-1:0] vcol;
		logic             neg;
		logic [31:0]      dacc;
		logic [31:0]      hacc;
	} card_state_t;

	typedef struct packed {
		kind_t       card_kind;
		kw_t         keyword_code;
		logic [9:0]  axis_index;
		logic        bool_value;
		logic [31:0] int_value;
		logic        int_was_hex;
		logic        int_error;
		logic        junk_after_value;
		logic        bool_wrong_column;
		logic        name_blank;
	} result_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_BLANK) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] b);
		return ((b >= "A") && (b <= "Z")) ? (b | CASE_BIT) : b;
	endfunction

endpackage

>>> rtl/hcc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_if
// Stream channels: card bytes in, one classification result per card out.
// ----------------------------------------------------------------------------
interface hcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] card_byte;

	modport source(output valid, output card_byte, input ready);
	modport sink(input valid, input card_byte, output ready);
endinterface

interface hcc_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         card_kind;
	logic [3:0]         keyword_code;
	logic [9:0]         axis_index;
	logic               bool_value;
	logic signed [31:0] int_value;
	logic               int_was_hex;
	logic               int_error;
	logic               junk_after_value;
	logic               bool_wrong_column;
	logic               name_blank;

	modport source(output valid, output card_kind, output keyword_code, output axis_index,
		output bool_value, output int_value, output int_was_hex, output int_error,
		output junk_after_value, output bool_wrong_column, output name_blank, input ready);
	modport sink(input valid, input card_kind, input keyword_code, input axis_index,
		input bool_value, input int_value, input int_was_hex, input int_error,
		input junk_after_value, input bool_wrong_column, input name_blank, output ready);
endinterface

>>> rtl/header_card_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_card_classifier_unit
// Classifies 80-byte header cards streamed one byte per transfer.
// ----------------------------------------------------------------------------
// Channels: stream (sink) takes raw card bytes, one per transfer; result
// (source) gives one transfer per card. Both use valid/ready; a transfer
// happens on a rising edge with valid and ready high. The column within the
// card is counted internally, starting at zero after reset.
// Pipeline: input register, card scanner (state plus a one-card snapshot
// register), result builder into the output register. A card's final state
// fills the snapshot register, and its result then the output register.
// Throughput: one byte per cycle, set by the scanner update, unless stalled.
// Reset clears the column, the card state and all valid flags.
// Receiver stall: the output register and the snapshot register each hold
// one card, so bytes keep flowing through a full card while the result
// waits; stream.ready drops only when the last byte of a further card
// finds both registers occupied.
// ----------------------------------------------------------------------------
module header_card_classifier_unit (
	input  logic                clk,
	input  logic                arst_n,
	hcc_byte_if.sink            stream,
	hcc_result_if.source        result
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last;
	logic                 consume;
	logic                 snap_take;
	logic                 snap_valid_s2;
	hcc_pkg::card_state_t snap_s2;
	hcc_pkg::result_t     built;
	logic                 res_valid_q;
	hcc_pkg::result_t     res_q;

	assign snap_take    = snap_valid_s2 && (!res_valid_q || result.ready);
	assign consume      = valid_s1 && !(last && snap_valid_s2 && !snap_take);
	assign stream.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) byte_s1 <= stream.card_byte;
	end

	hcc_scanner u_scanner (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (consume),
		.card_byte     (byte_s1),
		.last          (last),
		.snap_take     (snap_take),
		.snap_valid_s2 (snap_valid_s2),
		.snap_s2       (snap_s2)
	);

	hcc_builder u_builder (
		.st  (snap_s2),
		.res (built)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (snap_take) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_take) res_q <= built;
	end

	assign result.valid             = res_valid_q;
	assign result.card_kind         = res_q.card_kind;
	assign result.keyword_code      = res_q.keyword_code;
	assign result.axis_index        = res_q.axis_index;
	assign result.bool_value        = res_q.bool_value;
	assign result.int_value         = $signed(res_q.int_value);
	assign result.int_was_hex       = res_q.int_was_hex;
	assign result.int_error         = res_q.int_error;
	assign result.junk_after_value  = res_q.junk_after_value;
	assign result.bool_wrong_column = res_q.bool_wrong_column;
	assign result.name_blank        = res_q.name_blank;

	a_card_done: assert property (@(posedge clk) disable iff (!arst_n)
		consume && last |=> snap_valid_s2)
		else $error("finished card left no snapshot");

	a_end_kw: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.card_kind == hcc_pkg::KIND_END |->
		result.keyword_code == hcc_pkg::KW_END)
		else $error("end card without END keyword");

	a_int_only_number: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.card_kind != hcc_pkg::KIND_NUMBER |->
		result.int_value == 0 && !result.int_error && !result.int_was_hex)
		else $error("integer fields set on a non-number card");

endmodule

>>> rtl/hcc_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_scanner
// Per-byte card state: column count, name capture, decimal and hex readers.
// Holds the final state of a finished card in a snapshot register.
// ----------------------------------------------------------------------------
module hcc_scanner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          card_byte,
	output logic                last,
	input  logic                snap_take,
	output logic                snap_valid_s2,
	output hcc_pkg::card_state_t snap_s2
);

	logic [hcc_pkg::COL_W-1:0] col_q;
	hcc_pkg::card_state_t      st_q;
	hcc_pkg::card_state_t      nx;
	logic                      first;
	logic                      feed;
	logic                      hex_tail;
	logic                      dig;
	logic [3:0]                dv;
	logic [7:0]                lc;

	assign last = (col_q == hcc_pkg::CARD_LAST);
	assign dig  = hcc_pkg::is_digit(card_byte);
	assign dv   = card_byte[3:0];
	assign lc   = card_byte | hcc_pkg::CASE_BIT;

	always_comb begin
		nx       = st_q;
		first    = 1'b0;
		feed     = 1'b0;
		hex_tail = 1'b0;
		if (col_q < hcc_pkg::EQ_COLUMN) begin
			nx.name = {st_q.name[55:0], card_byte};
		end else if (col_q == hcc_pkg::EQ_COLUMN) begin
			if (card_byte == hcc_pkg::CH_EQ) nx.eq = 1'b1;
		end else if (st_q.found) begin
			feed = 1'b1;
		end else if (card_byte != hcc_pkg::CH_BLANK) begin
			feed     = 1'b1;
			first    = 1'b1;
			nx.found = 1'b1;
			nx.hchk  = 1'b1;
			nx.fvb   = card_byte;
			nx.vcol  = col_q;
		end

		if (feed) begin
			// token hex detection
			if (nx.hchk) begin
				if (card_byte == hcc_pkg::CH_BLANK || card_byte == hcc_pkg::CH_SLASH)
					nx.hchk = 1'b0;
				else if (lc >= 8'h61)
					nx.ishex = 1'b1;
			end

			// decimal reader and junk scan
			if (first && card_byte == hcc_pkg::CH_PLUS) begin
				nx.djact = 1'b1;
			end else begin
				if (first) nx.djact = 1'b1;
				case (st_q.dphase) inside
					hcc_pkg::DP_PRE: begin
						if (hcc_pkg::is_space(card_byte)) begin
							nx.dphase = hcc_pkg::DP_PRE;
						end else if (card_byte == hcc_pkg::CH_PLUS ||
							card_byte == hcc_pkg::CH_MINUS) begin
							if (card_byte == hcc_pkg::CH_MINUS) nx.neg = 1'b1;
							nx.dphase = hcc_pkg::DP_NEEDDIG;
						end else if (dig) begin
							nx.dacc   = {28'd0, dv};
							nx.dphase = hcc_pkg::DP_DIG;
						end else begin
							nx.dphase = hcc_pkg::DP_FAIL;
						end
					end
					hcc_pkg::DP_NEEDDIG, hcc_pkg::DP_DIG: begin
						if (dig) begin
							nx.dacc = {st_q.dacc[28:0], 3'b000} + {st_q.dacc[30:0], 1'b0}
								+ {28'd0, dv};
							nx.dphase = hcc_pkg::DP_DIG;
						end else begin
							nx.dphase = (st_q.dphase == hcc_pkg::DP_DIG) ?
								hcc_pkg::DP_OK : hcc_pkg::DP_FAIL;
						end
					end
					default: begin
						nx.dphase = st_q.dphase;
					end
				endcase
				if (nx.djact && !(dig || card_byte == hcc_pkg::CH_BLANK ||
					card_byte == hcc_pkg::CH_MINUS)) begin
					nx.djact = 1'b0;
					if (card_byte != hcc_pkg::CH_SLASH) nx.djunk = 1'b1;
				end
			end

			// hex reader
			if (first && (card_byte == hcc_pkg::CH_PLUS || card_byte == hcc_pkg::CH_MINUS)) begin
				if (card_byte == hcc_pkg::CH_MINUS) nx.hneg = 1'b1;
			end else begin
				if (st_q.hphase == hcc_pkg::HP_DIG) begin
					if (dig) begin
						nx.hacc = {st_q.hacc[27:0], dv};
					end else if (lc >= "a" && lc <= "f") begin
						nx.hacc = {st_q.hacc[27:0], 4'(lc - 8'h57)};
					end else begin
						nx.hphase = hcc_pkg::HP_TAIL;
						hex_tail  = 1'b1;
					end
				end
				if ((st_q.hphase == hcc_pkg::HP_TAIL || hex_tail) &&
					card_byte != hcc_pkg::CH_BLANK) begin
					nx.hphase = hcc_pkg::HP_DONE;
					if (card_byte != hcc_pkg::CH_SLASH) nx.hjunk = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			st_q          <= '0;
			snap_valid_s2 <= 1'b0;
		end else begin
			if (step) begin
				if (last) begin
					col_q <= '0;
					st_q  <= '0;
				end else begin
					col_q <= col_q + 1'b1;
					st_q  <= nx;
				end
			end
			if (step && last) snap_valid_s2 <= 1'b1;
			else if (snap_take) snap_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last) snap_s2 <= nx;
	end

endmodule

>>> rtl/hcc_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_builder
// Turns the final state of a card into its result: kind, keyword, values.
// ----------------------------------------------------------------------------
module hcc_builder (
	input  hcc_pkg::card_state_t st,
	output hcc_pkg::result_t     res
);

	logic [7:0]  b5, b6, b7;
	logic [9:0]  d0, d1, d2;
	logic [9:0]  axis;
	logic        naxn;
	logic [63:0] folded;
	hcc_pkg::kw_t   code;
	hcc_pkg::kind_t kind;
	hcc_pkg::kind_t vkind;

	assign b5 = st.name[23:16];
	assign b6 = st.name[15:8];
	assign b7 = st.name[7:0];
	assign d0 = {6'd0, b5[3:0]};
	assign d1 = {6'd0, b6[3:0]};
	assign d2 = {6'd0, b7[3:0]};

	always_comb begin
		for (int i = 0; i < 8; i++) folded[8*i +: 8] = hcc_pkg::fold(st.name[8*i +: 8]);
	end

	always_comb begin
		naxn = 1'b0;
		axis = '0;
		if (st.name[63:24] == hcc_pkg::NAXIS_STEM && b5 >= "1" && b5 <= "9") begin
			if (b6 == hcc_pkg::CH_BLANK && b7 == hcc_pkg::CH_BLANK) begin
				naxn = 1'b1;
				axis = d0;
			end else if (hcc_pkg::is_digit(b6) && b7 == hcc_pkg::CH_BLANK) begin
				naxn = 1'b1;
				axis = 10'(d0 * 10'd10) + d1;
			end else if (hcc_pkg::is_digit(b6) && hcc_pkg::is_digit(b7)) begin
				naxn = 1'b1;
				axis = 10'(d0 * 10'd100) + 10'(d1 * 10'd10) + d2;
			end
		end
	end

	always_comb begin
		if (st.name == hcc_pkg::NAME_SIMPLE)        code = hcc_pkg::KW_SIMPLE;
		else if (st.name == hcc_pkg::NAME_XTENSION) code = hcc_pkg::KW_XTENSION;
		else if (st.name == hcc_pkg::NAME_BITPIX)   code = hcc_pkg::KW_BITPIX;
		else if (st.name == hcc_pkg::NAME_NAXIS)    code = hcc_pkg::KW_NAXIS;
		else if (st.name == hcc_pkg::NAME_PCOUNT)   code = hcc_pkg::KW_PCOUNT;
		else if (st.name == hcc_pkg::NAME_GCOUNT)   code = hcc_pkg::KW_GCOUNT;
		else if (st.name == hcc_pkg::NAME_END)      code = hcc_pkg::KW_END;
		else if (naxn)                              code = hcc_pkg::KW_NAXISN;
		else                                        code = hcc_pkg::KW_OTHER;
	end

	always_comb begin
		if (!st.found || st.fvb == hcc_pkg::CH_SLASH)
			vkind = hcc_pkg::KIND_NONE;
		else if (st.fvb == hcc_pkg::CH_QUOTE)
			vkind = hcc_pkg::KIND_STRING;
		else if (st.fvb == hcc_pkg::CH_T)
			vkind = hcc_pkg::KIND_BOOL;
		else if (st.fvb == hcc_pkg::CH_F && st.vcol == hcc_pkg::COL_W'(hcc_pkg::BOOL_COLUMN))
			vkind = hcc_pkg::KIND_BOOL;
		else if ((st.fvb >= "A" && st.fvb <= "F") || (st.fvb >= "a" && st.fvb <= "f") ||
			st.fvb == hcc_pkg::CH_PLUS || st.fvb == hcc_pkg::CH_MINUS ||
			st.fvb == hcc_pkg::CH_DOT || hcc_pkg::is_digit(st.fvb))
			vkind = hcc_pkg::KIND_NUMBER;
		else
			vkind = hcc_pkg::KIND_CORRUPT;

		if (code == hcc_pkg::KW_END)
			kind = hcc_pkg::KIND_END;
		else if (!st.eq || folded == hcc_pkg::NAME_HISTORY || folded == hcc_pkg::NAME_COMMENT)
			kind = hcc_pkg::KIND_COMMENT;
		else
			kind = vkind;
	end

	always_comb begin
		res              = '0;
		res.card_kind    = kind;
		res.keyword_code = code;
		res.axis_index   = axis;
		if (kind <= hcc_pkg::KIND_CORRUPT)
			res.name_blank = (st.name == hcc_pkg::NAME_BLANK);
		if (kind == hcc_pkg::KIND_BOOL && st.fvb == hcc_pkg::CH_T) begin
			res.bool_value        = 1'b1;
			res.bool_wrong_column = (st.vcol != hcc_pkg::COL_W'(hcc_pkg::BOOL_COLUMN));
		end
		if (kind == hcc_pkg::KIND_NUMBER) begin
			if (st.ishex) begin
				res.int_value        = st.hneg ? (32'd0 - st.hacc) : st.hacc;
				res.int_was_hex      = 1'b1;
				res.junk_after_value = st.hjunk;
			end else if (st.dphase == hcc_pkg::DP_DIG || st.dphase == hcc_pkg::DP_OK) begin
				res.int_value        = st.neg ? (32'd0 - st.dacc) : st.dacc;
				res.junk_after_value = st.djunk;
			end else begin
				res.int_error = 1'b1;
			end
		end
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams 80-byte header cards into header_card_classifier_unit. Each byte
// is fed to a card scanner model at its transfer. Each card's classification
// is queued and compared field by field with the next result transfer.
// Directed cards hit each keyword, card kind and number-reading corner.
// Random cards, mostly well formed, follow. Traffic uses three idle profiles.
// ----------------------------------------------------------------------------
module testbench;

	localparam int QUIET_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 10;
	localparam int RANDOM_CARDS = 2;

	logic clk;
	logic arst_n;

	hcc_byte_if   byte_link();
	hcc_result_if result_link();

	header_card_classifier_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.stream(byte_link),
		.result(result_link)
	);

	logic [7:0]        header_bytes[$];
	hcc_pkg::result_t  pending_verdicts[$];
	logic [7:0]        card_img[hcc_pkg::CARD_BYTES];

	int total_bytes;
	int bytes_sent = 0;
	int quiet = 0;
	int mismatches = 0;
	int cards_checked = 0;
	int kinds_seen[7] = '{default: 0};
	int hex_seen = 0;
	int errors_seen = 0;
	int junk_seen = 0;

	// scanner model state
	logic [6:0]        col = '0;
	logic [63:0]       name_reg = '0;
	logic              has_eq = 1'b0;
	logic              found = 1'b0;
	logic              hscan = 1'b0;
	logic              ishex = 1'b0;
	logic              djact = 1'b0;
	logic              djunk = 1'b0;
	logic              hneg = 1'b0;
	logic              hjunk = 1'b0;
	hcc_pkg::dphase_t  dph = hcc_pkg::DP_PRE;
	hcc_pkg::hphase_t  hph = hcc_pkg::HP_DIG;
	logic [7:0]        first_b = '0;
	logic [6:0]        first_col = '0;
	logic              dneg = 1'b0;
	logic [31:0]       dacc = '0;
	logic [31:0]       hacc = '0;

	function automatic bit numeral(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit white(logic [7:0] b);
		return b == " " || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	task automatic clear_card();
		col = '0;
		name_reg = '0;
		{has_eq, found, hscan, ishex, djact, djunk, hneg, hjunk} = '0;
		dph = hcc_pkg::DP_PRE;
		hph = hcc_pkg::HP_DIG;
		first_b = '0;
		first_col = '0;
		dneg = 1'b0;
		dacc = '0;
		hacc = '0;
	endtask

	task automatic scan_value(logic [7:0] b, bit first);
		logic [7:0] lo;
		lo = b | 8'h20;
		if (hscan) begin
			if (b == " " || b == "/")
				hscan = 1'b0;
			else if (lo >= 8'h61)
				ishex = 1'b1;
		end
		if (first && b == "+") begin
			djact = 1'b1;
		end else begin
			if (first)
				djact = 1'b1;
			case (dph)
				hcc_pkg::DP_PRE: begin
					if (!white(b)) begin
						if (b == "+" || b == "-") begin
							if (b == "-")
								dneg = 1'b1;
							dph = hcc_pkg::DP_NEEDDIG;
						end else if (numeral(b)) begin
							dacc = 32'(b - "0");
							dph = hcc_pkg::DP_DIG;
						end else begin
							dph = hcc_pkg::DP_FAIL;
						end
					end
				end
				hcc_pkg::DP_NEEDDIG, hcc_pkg::DP_DIG: begin
					if (numeral(b)) begin
						dacc = dacc * 32'd10 + 32'(b - "0");
						dph = hcc_pkg::DP_DIG;
					end else begin
						dph = (dph == hcc_pkg::DP_DIG) ? hcc_pkg::DP_OK : hcc_pkg::DP_FAIL;
					end
				end
				default: ;
			endcase
			if (djact && !(numeral(b) || b == " " || b == "-")) begin
				djact = 1'b0;
				if (b != "/")
					djunk = 1'b1;
			end
		end
		if (first && (b == "+" || b == "-")) begin
			if (b == "-")
				hneg = 1'b1;
		end else begin
			if (hph == hcc_pkg::HP_DIG) begin
				if (numeral(b))
					hacc = hacc * 32'd16 + 32'(b - "0");
				else if (lo >= "a" && lo <= "f")
					hacc = hacc * 32'd16 + 32'd10 + 32'(lo - "a");
				else
					hph = hcc_pkg::HP_TAIL;
			end
			if (hph == hcc_pkg::HP_TAIL && b != " ") begin
				hph = hcc_pkg::HP_DONE;
				if (b != "/")
					hjunk = 1'b1;
			end
		end
	endtask

	function automatic hcc_pkg::result_t card_verdict();
		hcc_pkg::result_t r;
		logic [63:0] folded;
		logic [7:0] d0, d1, d2, c;
		r = '0;
		r.keyword_code = hcc_pkg::KW_OTHER;
		d0 = name_reg[23:16];
		d1 = name_reg[15:8];
		d2 = name_reg[7:0];
		for (int i = 0; i < 8; i++) begin
			c = name_reg[8*i +: 8];
			folded[8*i +: 8] = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
		end
		if (name_reg[63:24] == "NAXIS" && d0 >= "1" && d0 <= "9") begin
			if (d1 == " " && d2 == " ") begin
				r.keyword_code = hcc_pkg::KW_NAXISN;
				r.axis_index = 10'(d0 - "0");
			end else if (numeral(d1) && d2 == " ") begin
				r.keyword_code = hcc_pkg::KW_NAXISN;
				r.axis_index = 10'((d0 - "0") * 10 + (d1 - "0"));
			end else if (numeral(d1) && numeral(d2)) begin
				r.keyword_code = hcc_pkg::KW_NAXISN;
				r.axis_index = 10'((d0 - "0") * 100 + (d1 - "0") * 10 + (d2 - "0"));
			end
		end
		case (name_reg)
			"SIMPLE  ": r.keyword_code = hcc_pkg::KW_SIMPLE;
			"XTENSION": r.keyword_code = hcc_pkg::KW_XTENSION;
			"BITPIX  ": r.keyword_code = hcc_pkg::KW_BITPIX;
			"NAXIS   ": r.keyword_code = hcc_pkg::KW_NAXIS;
			"PCOUNT  ": r.keyword_code = hcc_pkg::KW_PCOUNT;
			"GCOUNT  ": r.keyword_code = hcc_pkg::KW_GCOUNT;
			"END     ": r.keyword_code = hcc_pkg::KW_END;
			default: ;
		endcase

		if (r.keyword_code == hcc_pkg::KW_END)
			r.card_kind = hcc_pkg::KIND_END;
		else if (!has_eq || folded == "history " || folded == "comment ")
			r.card_kind = hcc_pkg::KIND_COMMENT;
		else if (!found || first_b == "/")
			r.card_kind = hcc_pkg::KIND_NONE;
		else if (first_b == hcc_pkg::CH_QUOTE)
			r.card_kind = hcc_pkg::KIND_STRING;
		else if (first_b == "T" || (first_b == "F" && first_col == hcc_pkg::BOOL_COLUMN))
			r.card_kind = hcc_pkg::KIND_BOOL;
		else if (first_b == "F" || (first_b >= "A" && first_b <= "E")
				|| (first_b >= "a" && first_b <= "f") || first_b == "+"
				|| first_b == "-" || first_b == "." || numeral(first_b))
			r.card_kind = hcc_pkg::KIND_NUMBER;
		else
			r.card_kind = hcc_pkg::KIND_CORRUPT;

		if (r.card_kind <= hcc_pkg::KIND_CORRUPT)
			r.name_blank = (name_reg == "        ");
		if (r.card_kind == hcc_pkg::KIND_BOOL && first_b == "T") begin
			r.bool_value = 1'b1;
			r.bool_wrong_column = (first_col != hcc_pkg::BOOL_COLUMN);
		end
		if (r.card_kind == hcc_pkg::KIND_NUMBER) begin
			if (ishex) begin
				r.int_value = hneg ? -hacc : hacc;
				r.int_was_hex = 1'b1;
				r.junk_after_value = hjunk;
			end else if (dph == hcc_pkg::DP_DIG || dph == hcc_pkg::DP_OK) begin
				r.int_value = dneg ? -dacc : dacc;
				r.junk_after_value = djunk;
			end else begin
				r.int_error = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic classify_byte(logic [7:0] b);
		if (col < 8) begin
			name_reg[8*(7-col) +: 8] = b;
		end else if (col == 8) begin
			if (b == "=")
				has_eq = 1'b1;
		end else if (found) begin
			scan_value(b, 1'b0);
		end else if (b != " ") begin
			found = 1'b1;
			hscan = 1'b1;
			first_b = b;
			first_col = col;
			scan_value(b, 1'b1);
		end
		if (col == hcc_pkg::CARD_BYTES - 1) begin
			pending_verdicts.push_back(card_verdict());
			clear_card();
		end else begin
			col = col + 1'b1;
		end
	endtask

	task automatic put_text(int at, string s);
		for (int i = 0; i < s.len(); i++)
			if (at + i < hcc_pkg::CARD_BYTES)
				card_img[at + i] = s[i];
	endtask

	// negative position right-justifies the value to end at the bool column
	task automatic compose(string name, logic [7:0] mark, int at, string value);
		for (int i = 0; i < hcc_pkg::CARD_BYTES; i++)
			card_img[i] = " ";
		put_text(0, (name.len() > 8) ? name.substr(0, 7) : name);
		card_img[8] = mark;
		put_text((at < 0) ? hcc_pkg::BOOL_COLUMN + 1 - value.len() : at, value);
	endtask

	task automatic ship();
		foreach (card_img[i])
			header_bytes.push_back(card_img[i]);
	endtask

	task automatic random_card();
		string nm, val, pool;
		int at, n, k;
		bit raw_name, raw_value;
		raw_name = 1'b0;
		raw_value = 1'b0;
		pool = "0123456789ABCDEFabcdef";
		case ($urandom_range(12))
			0: nm = "SIMPLE";
			1: nm = "XTENSION";
			2: nm = "BITPIX";
			3: nm = "NAXIS";
			4: begin
				if ($urandom_range(3) == 0)
					nm = $sformatf("NAXIS%03d", $urandom_range(1200));
				else
					nm = $sformatf("NAXIS%0d", $urandom_range(1200));
			end
			5: nm = "PCOUNT";
			6: nm = "GCOUNT";
			7: nm = "END";
			8: begin
				k = $urandom_range(2);
				nm = (k == 0) ? "HISTORY" : (k == 1) ? "history" : "HiStOrY";
			end
			9: begin
				k = $urandom_range(2);
				nm = (k == 0) ? "COMMENT" : (k == 1) ? "comment" : "cOmMeNt";
			end
			10: nm = "";
			11: begin
				nm = "";
				n = $urandom_range(1, 8);
				repeat (n) begin
					k = $urandom_range(25);
					nm = {nm, $sformatf("%c", 8'("A" + k))};
				end
			end
			default: begin
				nm = "";
				raw_name = 1'b1;
			end
		endcase

		val = "";
		case ($urandom_range(11))
			0: val = "'some text'";
			1: val = "T";
			2: val = "F";
			3, 4, 5: begin
				k = $urandom_range(3);
				if (k == 0)
					val = "-";
				else if (k == 1)
					val = "+";
				n = ($urandom_range(3) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 9);
				repeat (n) begin
					k = $urandom_range(9);
					val = {val, pool.substr(k, k)};
				end
			end
			6, 7: begin
				k = $urandom_range(3);
				if (k == 0)
					val = "-";
				else if (k == 1)
					val = "+";
				n = $urandom_range(1, 10);
				repeat (n) begin
					k = $urandom_range(21);
					val = {val, pool.substr(k, k)};
				end
			end
			8: val = "/ remark";
			9: val = "";
			10: begin
				pool = " +-./0123456789xE\t";
				n = $urandom_range(1, 6);
				repeat (n) begin
					k = $urandom_range(pool.len() - 1);
					val = {val, pool.substr(k, k)};
				end
			end
			default: raw_value = 1'b1;
		endcase
		if ($urandom_range(1))
			val = {val, ($urandom_range(1)) ? " / note" : " x9"};
		at = ($urandom_range(1)) ? hcc_pkg::BOOL_COLUMN + 1 - val.len() : $urandom_range(9, 40);
		if (at < 9)
			at = 9;

		compose(nm, ($urandom_range(99) < 85) ? 8'("=") : 8'($urandom_range(255)), at, val);
		if (raw_name)
			for (int i = 0; i < 8; i++)
				card_img[i] = 8'($urandom_range(255));
		if (raw_value) begin
			at = $urandom_range(9, 60);
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				card_img[at + i] = 8'($urandom_range(255));
		end
		k = $urandom_range(99);
		if (k < 8) begin
			foreach (card_img[i])
				card_img[i] = 8'($urandom_range(255));
		end else if (k < 18) begin
			card_img[$urandom_range(hcc_pkg::CARD_BYTES - 1)] = 8'($urandom_range(255));
		end
		ship();
	endtask

	function automatic int idle_pct(bit sender);
		int stage;
		stage = bytes_sent * 3 / total_bytes;
		if (stage == 0)
			return sender ? 28 : 58;
		if (stage == 1)
			return sender ? 58 : 28;
		return 0;
	endfunction

	task automatic match_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: card %0d %s expected %0h actual %0h",
				$time, cards_checked, field, want, got);
			mismatches++;
		end
	endtask

	task automatic check_verdict();
		hcc_pkg::result_t want;
		if (pending_verdicts.size() == 0) begin
			$display("%0t: result transfer with no card pending, kind %0d",
				$time, result_link.card_kind);
			mismatches++;
		end else begin
			want = pending_verdicts.pop_front();
			match_field("card_kind", 32'(want.card_kind), 32'(result_link.card_kind));
			match_field("keyword_code", 32'(want.keyword_code),
				32'(result_link.keyword_code));
			match_field("axis_index", 32'(want.axis_index), 32'(result_link.axis_index));
			match_field("bool_value", 32'(want.bool_value), 32'(result_link.bool_value));
			match_field("int_value", want.int_value, result_link.int_value);
			match_field("int_was_hex", 32'(want.int_was_hex), 32'(result_link.int_was_hex));
			match_field("int_error", 32'(want.int_error), 32'(result_link.int_error));
			match_field("junk_after_value", 32'(want.junk_after_value),
				32'(result_link.junk_after_value));
			match_field("bool_wrong_column", 32'(want.bool_wrong_column),
				32'(result_link.bool_wrong_column));
			match_field("name_blank", 32'(want.name_blank), 32'(result_link.name_blank));
			kinds_seen[want.card_kind]++;
			hex_seen += int'(want.int_was_hex);
			errors_seen += int'(want.int_error);
			junk_seen += int'(want.junk_after_value);
			cards_checked++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_link.valid <= 1'b0;
			byte_link.card_byte <= '0;
		end else begin
			if (byte_link.valid && byte_link.ready) begin
				classify_byte(byte_link.card_byte);
				bytes_sent <= bytes_sent + 1;
			end
			if (!byte_link.valid || byte_link.ready) begin
				if (header_bytes.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
					byte_link.valid <= 1'b1;
					byte_link.card_byte <= header_bytes.pop_front();
				end else begin
					byte_link.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_link.ready <= 1'b0;
		end else begin
			if (result_link.valid && result_link.ready)
				check_verdict();
			result_link.ready <= ($urandom_range(99) >= idle_pct(1'b0));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_link.valid && byte_link.ready) || (result_link.valid && result_link.ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("FAIL header_card_classifier_unit");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;

		compose("SIMPLE", "=", -1, "T"); ship();
		compose("BITPIX", "=", -1, "-2147483648"); ship();
		compose("NAXIS", "=", 10, ""); ship();
		compose("NAXIS1", "=", -1, "4294967297"); ship();
		compose("NAXIS12", "=", 10, "+12 / ok"); ship();
		compose("NAXIS999", "=", 10, "99999999999 junk"); ship();
		compose("NAXIS01", "=", 10, "- 3"); ship();
		compose("NAXIS1A", "=", 10, "T"); ship();
		compose("XTENSION", "=", 10, "'IMAGE   '"); ship();
		compose("PCOUNT", "=", 12, "/ only a note"); ship();
		compose("GCOUNT", "=", 10, "+-5"); ship();
		compose("END", "=", 10, "junk"); ship();
		compose("comMent", "=", 10, "5"); ship();
		compose("NOEQ", " ", 10, "= 7"); ship();
		compose("BOOLF", "=", -1, "F"); ship();
		compose("HEXV", "=", 10, "-Ff / x"); ship();
		compose("HEXJ", "=", 10, "+C0FFEE q"); ship();
		compose("DECJ", "=", 10, "123.5"); ship();
		compose("TABS", "=", 10, "+\t7"); ship();
		compose("", "=", -1, "abc"); ship();
		// name with NUL and all-ones bytes, value opening with an all-ones byte
		compose("ODD", "=", 10, "");
		card_img[1] = 8'h00;
		card_img[6] = 8'hFF;
		card_img[10] = 8'hFF;
		ship();
		compose("END", 8'h00, 10, ""); ship();

		repeat (RANDOM_CARDS)
			random_card();
		total_bytes = header_bytes.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (byte_link.valid || header_bytes.size() != 0 || pending_verdicts.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d cards in %0d byte transfers under three idle profiles.",
			cards_checked, bytes_sent);
		$display("Kinds str/bool/num/none/corrupt/comm/end %0d/%0d/%0d/%0d/%0d/%0d/%0d, %s",
			kinds_seen[hcc_pkg::KIND_STRING], kinds_seen[hcc_pkg::KIND_BOOL],
			kinds_seen[hcc_pkg::KIND_NUMBER], kinds_seen[hcc_pkg::KIND_NONE],
			kinds_seen[hcc_pkg::KIND_CORRUPT], kinds_seen[hcc_pkg::KIND_COMMENT],
			kinds_seen[hcc_pkg::KIND_END],
			$sformatf("hex %0d, int errors %0d, junk %0d", hex_seen, errors_seen, junk_seen));
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("PASS header_card_classifier_unit");
		else
			$display("FAIL header_card_classifier_unit");
		$finish;
	end

endmodule

>>> sim.f
rtl/hcc_pkg.sv
rtl/hcc_if.sv
rtl/hcc_scanner.sv
rtl/hcc_builder.sv
rtl/header_card_classifier_unit.sv
sim/testbench.sv
